// ===== rtl/oss_pkg.sv =====
package oss_pkg;

  // Item kinds carried on the kind field
  typedef enum logic [1:0] {
    KIND_BUFFER = 2'd0,
    KIND_SCAN   = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_STOP_LEVEL  = 3'd0,
    CFG_CLEAR_LEVEL = 3'd1,
    CFG_CLEAR_LIMIT = 3'd2,
    CFG_CALM_NEEDED = 3'd3,
    CFG_SLEEP_SECS  = 3'd4,
    CFG_SCAN_RATE   = 3'd5
  } cfg_idx_e;

  localparam int unsigned LevelW    = 15;
  localparam int unsigned CountW    = 16;
  localparam int unsigned RateW     = 10;
  localparam int unsigned IntervalW = 24;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned ProductW  = IntervalW + RateW;

  // Saturating increment of a 16 bit counter
  function automatic logic [CountW-1:0] sat_inc16(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    if (v == {CountW{1'b1}}) begin
      r = v;
    end else begin
      r = v + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/overload_stop_supervisor.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+----------------------------------------------
// input    | in_valid_i / in_ready_o   | kind_i, buffer_level_i, scan_interval_i
// result   | out_valid_o / out_ready_i | motion_*, clear_request_o, stage_*, status
// config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One transaction per clock sustained while results are taken; a result is offered
// once its transaction has passed the input register, then the result register, and
// can be taken at the next edge. All decisions are made in the single combinational
// step between those two registers; the scan-rate check uses one 24x10 multiply there.
// Reset (rst_ni low, asynchronous) clears the state flags, counters and valid bits and
// loads the register defaults. A stalled result holds; the input register keeps
// accepting while it is empty or the result register is free or being drained.
module overload_stop_supervisor
  import oss_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic signed [15:0]    buffer_level_i,
  input  logic [IntervalW-1:0]  scan_interval_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  motion_cmd_valid_o,
  output logic                  motion_go_o,
  output logic                  clear_request_o,
  output logic                  stage_cmd_valid_o,
  output logic                  stage_sleep_o,
  output logic                  motion_stopped_o,
  output logic                  stage_asleep_o,
  output logic [CountW-1:0]     clears_so_far_o
);

  localparam logic [ProductW-1:0] TicksLimit = ProductW'(TICKS_PER_SECOND);

  // configuration registers
  logic [LevelW-1:0] stop_level_q, clear_level_q;
  logic [CountW-1:0] clear_limit_q, calm_needed_q, sleep_secs_q;
  logic [RateW-1:0]  scan_rate_q;

  // supervisor state
  logic              stopped_q, stopped_d;
  logic              overload_q, overload_d;
  logic              slow_scan_q, slow_scan_d;
  logic              sleeping_q, sleeping_d;
  logic [CountW-1:0] clear_cnt_q, clear_cnt_d;
  logic [CountW-1:0] calm_cnt_q, calm_cnt_d;
  logic [CountW-1:0] elapsed_q, elapsed_d;

  // input register
  logic                 s1_valid_q;
  logic [1:0]           s1_kind_q;
  logic signed [15:0]   s1_level_q;
  logic [IntervalW-1:0] s1_interval_q;

  // result register
  logic              out_valid_q;
  logic              mvalid_q, mvalid_d;
  logic              mgo_q, mgo_d;
  logic              clr_q, clr_d;
  logic              svalid_q, svalid_d;
  logic              ssleep_q, ssleep_d;

  logic              advance;
  logic [ProductW-1:0] product;
  logic              slow;
  logic              at_stop, at_clear;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_level_q  <= LevelW'(100);
      clear_level_q <= LevelW'(200);
      clear_limit_q <= CountW'(3);
      calm_needed_q <= CountW'(10);
      sleep_secs_q  <= CountW'(60);
      scan_rate_q   <= RateW'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STOP_LEVEL:  stop_level_q  <= cfg_wdata_i[LevelW-1:0];
        CFG_CLEAR_LEVEL: clear_level_q <= cfg_wdata_i[LevelW-1:0];
        CFG_CLEAR_LIMIT: clear_limit_q <= cfg_wdata_i;
        CFG_CALM_NEEDED: calm_needed_q <= cfg_wdata_i;
        CFG_SLEEP_SECS:  sleep_secs_q  <= cfg_wdata_i;
        CFG_SCAN_RATE:   scan_rate_q   <= cfg_wdata_i[RateW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_kind_q     <= kind_i;
      s1_level_q    <= buffer_level_i;
      s1_interval_q <= scan_interval_i;
    end
  end

  // level and scan-rate compares
  assign at_stop  = s1_level_q >= $signed({1'b0, stop_level_q});
  assign at_clear = s1_level_q >= $signed({1'b0, clear_level_q});
  assign product  = ProductW'(s1_interval_q) * ProductW'(scan_rate_q);
  assign slow     = product > TicksLimit;

  // decision logic for the item in the input register
  always_comb begin
    stopped_d   = stopped_q;
    overload_d  = overload_q;
    slow_scan_d = slow_scan_q;
    sleeping_d  = sleeping_q;
    clear_cnt_d = clear_cnt_q;
    calm_cnt_d  = calm_cnt_q;
    elapsed_d   = elapsed_q;
    mvalid_d    = 1'b0;
    mgo_d       = 1'b0;
    clr_d       = 1'b0;
    svalid_d    = 1'b0;
    ssleep_d    = 1'b0;

    unique case (kind_e'(s1_kind_q))
      KIND_BUFFER: begin
        if (at_stop) begin
          calm_cnt_d = '0;
          if (!overload_q && !stopped_q) begin
            mvalid_d   = 1'b1;
            overload_d = 1'b1;
            stopped_d  = 1'b1;
          end
          if (at_clear && overload_d && !sleeping_q) begin
            clear_cnt_d = sat_inc16(clear_cnt_q);
            clr_d       = 1'b1;
            if (clear_cnt_d >= clear_limit_q) begin
              svalid_d   = 1'b1;
              ssleep_d   = 1'b1;
              sleeping_d = 1'b1;
              elapsed_d  = '0;
            end
          end
        end else begin
          calm_cnt_d = sat_inc16(calm_cnt_q);
        end
        // a long enough calm run lifts an overload stop
        if (calm_cnt_d >= calm_needed_q && overload_d && stopped_d) begin
          clear_cnt_d = '0;
          mvalid_d    = 1'b1;
          mgo_d       = 1'b1;
          overload_d  = 1'b0;
          stopped_d   = 1'b0;
        end
      end
      KIND_SCAN: begin
        if (slow && !slow_scan_q && !stopped_q) begin
          mvalid_d    = 1'b1;
          slow_scan_d = 1'b1;
          stopped_d   = 1'b1;
        end else if (!slow && slow_scan_q && stopped_q) begin
          mvalid_d    = 1'b1;
          mgo_d       = 1'b1;
          slow_scan_d = 1'b0;
          stopped_d   = 1'b0;
        end
      end
      KIND_TICK: begin
        if (sleeping_q) begin
          if (elapsed_q >= sleep_secs_q) begin
            svalid_d    = 1'b1;
            sleeping_d  = 1'b0;
            clear_cnt_d = '0;
          end else begin
            elapsed_d = sat_inc16(elapsed_q);
          end
        end
      end
      default: ;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q   <= 1'b0;
      overload_q  <= 1'b0;
      slow_scan_q <= 1'b0;
      sleeping_q  <= 1'b0;
      clear_cnt_q <= '0;
      calm_cnt_q  <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        stopped_q   <= stopped_d;
        overload_q  <= overload_d;
        slow_scan_q <= slow_scan_d;
        sleeping_q  <= sleeping_d;
        clear_cnt_q <= clear_cnt_d;
        calm_cnt_q  <= calm_cnt_d;
        elapsed_q   <= elapsed_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      mvalid_q <= mvalid_d;
      mgo_q    <= mgo_d;
      clr_q    <= clr_d;
      svalid_q <= svalid_d;
      ssleep_q <= ssleep_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign motion_cmd_valid_o = mvalid_q;
  assign motion_go_o        = mgo_q;
  assign clear_request_o    = clr_q;
  assign stage_cmd_valid_o  = svalid_q;
  assign stage_sleep_o      = ssleep_q;
  // status fields track the state after the item last moved into the result register
  assign motion_stopped_o   = stopped_q;
  assign stage_asleep_o     = sleeping_q;
  assign clears_so_far_o    = clear_cnt_q;

endmodule

// ===== rtl/oss_checker.sv =====
module oss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        motion_cmd_valid_o,
  input logic        motion_go_o,
  input logic        clear_request_o,
  input logic        stage_cmd_valid_o,
  input logic        stage_sleep_o,
  input logic        motion_stopped_o,
  input logic        stage_asleep_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a resume leaves motion running, a stop leaves it held
  a_motion_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_cmd_valid_o |-> (motion_go_o != motion_stopped_o))
    else $error("motion command disagrees with motion state");

  // a sleep command leaves the stage asleep, a restart leaves it awake
  a_stage_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stage_cmd_valid_o |-> (stage_sleep_o == stage_asleep_o))
    else $error("stage command disagrees with stage state");

  // command values only come with their command
  a_cmd_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!motion_go_o || motion_cmd_valid_o) &&
                    (!stage_sleep_o || stage_cmd_valid_o))
    else $error("command value without command");

  // clears only happen under an overload stop, or with the resume that ends it
  a_clear_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_request_o |->
      motion_stopped_o || (motion_cmd_valid_o && motion_go_o))
    else $error("clear request while motion runs");

endmodule

bind overload_stop_supervisor oss_checker u_oss_checker (.*);
